// ===== rtl/core/cpr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared constants, types and state encodings for the command packet receiver.
// ----------------------------------------------------------------------------
package cpr_pkg;

  localparam int BUFFER_BYTES = 64;
  localparam int HEADER_BYTES = 4;
  localparam int SHORT_LIMIT  = 10;
  localparam int LEN_LIMIT    = BUFFER_BYTES - HEADER_BYTES;
  localparam int PTR_W        = $clog2(BUFFER_BYTES);
  localparam int RAM_DEPTH    = 2 * BUFFER_BYTES;
  localparam int RAM_AW       = PTR_W + 1;
  localparam int LEN_W        = 6;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_CRC_CHECK_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_LOAD_CODE   = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;

  typedef enum logic [2:0] {
    F_SUM_HI,
    F_SUM_LO,
    F_CMD,
    F_LEN,
    F_DATA
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_FETCH,
    B_LOAD,
    B_SHOW
  } back_state_t;

  typedef enum logic [1:0] {
    KIND_EMPTY,
    KIND_DATA,
    KIND_ERROR
  } desc_kind_t;

  typedef struct packed {
    desc_kind_t       kind;
    logic [7:0]       command;
    logic [LEN_W-1:0] len;
    logic             bank;
  } desc_t;

endpackage
`default_nettype wire

// ===== rtl/core/cpr_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpr_if
// Valid/ready channels: received bytes in, result items out.
// ----------------------------------------------------------------------------
interface cpr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cpr_res_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [7:0] command;
  logic [5:0] payload_len;
  logic [5:0] byte_index;
  logic [7:0] payload_byte;
  logic       last;

  modport source (output valid, output status, output command, output payload_len,
                  output byte_index, output payload_byte, output last, input ready);
  modport sink   (input valid, input status, input command, input payload_len,
                  input byte_index, input payload_byte, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/command_packet_receiver.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// command_packet_receiver
// Parses checksum/command/length/data packets and replays accepted payloads.
// ----------------------------------------------------------------------------
// A received byte is taken whenever the input is not stalled. A completed packet is
// queued and replayed from a double-banked payload buffer. The replay side picks
// up a queued descriptor from its idle state; an empty or failed packet then presents
// its single beat in the next cycle, and a payload of N bytes gives N beats, each
// through a buffer read, a load and a present step; a beat stays presented while
// the sink holds ready low. The byte input stalls only while two completed packets
// wait in the queue, the first of them still being replayed.
module command_packet_receiver import cpr_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  cpr_rx_if.sink                     rx,
  cpr_res_if.source                  res
);

  logic              crc_check_enable;
  logic [7:0]        long_load_code;
  logic              push;
  desc_t             push_desc;
  logic              pop;
  desc_t             head;
  logic              not_empty;
  logic              fifo_full;
  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [RAM_AW-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_check_enable <= 1'b0;
      long_load_code   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CRC_CHECK_ENABLE: crc_check_enable <= cfg_data[0];
        CFG_LONG_LOAD_CODE:   long_load_code   <= cfg_data[7:0];
        default:              long_load_code   <= long_load_code;
      endcase
    end
  end

  cpr_front u_front (
    .clk              (clk),
    .rst              (rst),
    .rx               (rx),
    .crc_check_enable (crc_check_enable),
    .long_load_code   (long_load_code),
    .fifo_full        (fifo_full),
    .push             (push),
    .push_desc        (push_desc),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata)
  );

  cpr_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cpr_desc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .full      (fifo_full)
  );

  cpr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .not_empty (not_empty),
    .pop       (pop),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res       (res)
  );

  a_error_single: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status |-> res.last && res.byte_index == '0 && res.payload_byte == '0)
    else $error("error beat is not a single zero beat");

  a_empty_single: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.payload_len == '0 |-> res.last && res.byte_index == '0)
    else $error("empty packet beat is not last");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.status && res.payload_len != '0 |-> res.byte_index < res.payload_len)
    else $error("byte index beyond payload length");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !fifo_full || pop)
    else $error("descriptor pushed into full queue");

endmodule
`default_nettype wire

// ===== rtl/core/cpr_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module cpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/cpr_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpr_front
// Packet parser: header decode, length clamp, payload write, checksum test.
// ----------------------------------------------------------------------------
module cpr_front import cpr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  cpr_rx_if.sink                 rx,
  input  wire logic              crc_check_enable,
  input  wire logic [7:0]        long_load_code,
  input  wire logic              fifo_full,
  output logic                   push,
  output desc_t                  push_desc,
  output logic                   ram_we,
  output logic [RAM_AW-1:0]      ram_waddr,
  output logic [7:0]             ram_wdata
);

  front_state_t     state, state_next;
  logic [15:0]      expected_sum;
  logic [15:0]      running_sum;
  logic [15:0]      sum_next;
  logic [7:0]       cmd;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] len_clamped;
  logic [PTR_W-1:0] pos;
  logic             bank;
  logic             acc;
  logic             last_data;

  assign rx.ready  = !fifo_full;
  assign acc       = rx.valid && rx.ready;
  assign sum_next  = running_sum + {8'd0, rx.rx_byte};
  assign last_data = ({{(8-PTR_W){1'b0}}, pos} == ({2'b00, len} - 8'd1));

  always_comb begin
    if (rx.rx_byte > 8'(LEN_LIMIT)) begin
      len_clamped = '0;
    end else if ((cmd != long_load_code) && (rx.rx_byte > 8'(SHORT_LIMIT))) begin
      len_clamped = '0;
    end else begin
      len_clamped = rx.rx_byte[LEN_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      F_SUM_HI: if (acc) state_next = F_SUM_LO;
      F_SUM_LO: if (acc) state_next = F_CMD;
      F_CMD:    if (acc) state_next = F_LEN;
      F_LEN: begin
        if (acc) state_next = (len_clamped == '0) ? F_SUM_HI : F_DATA;
      end
      F_DATA: begin
        if (acc && last_data) state_next = F_SUM_HI;
      end
      default:  state_next = F_SUM_HI;
    endcase
  end

  always_comb begin
    push              = 1'b0;
    push_desc.kind    = KIND_DATA;
    push_desc.command = cmd;
    push_desc.len     = len;
    push_desc.bank    = bank;
    ram_we            = 1'b0;
    ram_waddr         = {bank, pos};
    ram_wdata         = rx.rx_byte;
    case (state)
      F_LEN: begin
        push_desc.len  = len_clamped;
        push_desc.kind = KIND_EMPTY;
        push           = acc && (len_clamped == '0);
      end
      F_DATA: begin
        ram_we = acc;
        push   = acc && last_data;
        if (crc_check_enable && (sum_next != expected_sum)) begin
          push_desc.kind = KIND_ERROR;
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= F_SUM_HI;
      bank         <= 1'b0;
      expected_sum <= '0;
      running_sum  <= '0;
      cmd          <= '0;
      len          <= '0;
      pos          <= '0;
    end else begin
      state <= state_next;
      if (push) begin
        bank <= !bank;
      end
      if (acc) begin
        case (state)
          F_SUM_HI: expected_sum[15:8] <= rx.rx_byte;
          F_SUM_LO: expected_sum[7:0]  <= rx.rx_byte;
          F_CMD: begin
            cmd         <= rx.rx_byte;
            running_sum <= {8'd0, rx.rx_byte};
          end
          F_LEN: begin
            len         <= len_clamped;
            running_sum <= sum_next;
            pos         <= '0;
          end
          F_DATA: begin
            running_sum <= sum_next;
            pos         <= pos + 1'b1;
          end
          default: pos <= '0;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/cpr_desc_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpr_desc_fifo
// Two-entry queue of completed packet descriptors between parser and replay.
// ----------------------------------------------------------------------------
module cpr_desc_fifo import cpr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire desc_t push_desc,
  input  wire logic  pop,
  output desc_t      head,
  output logic       not_empty,
  output logic       full
);

  desc_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head      = slot[rd_ptr];
  assign not_empty = (count != 2'd0);
  assign full      = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/cpr_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpr_back
// Replay engine: reads the payload buffer and presents result beats.
// ----------------------------------------------------------------------------
module cpr_back import cpr_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire desc_t         head,
  input  wire logic          not_empty,
  output logic               pop,
  output logic               ram_re,
  output logic [RAM_AW-1:0]  ram_raddr,
  input  wire logic [7:0]    ram_rdata,
  cpr_res_if.source          res
);

  back_state_t      state, state_next;
  logic [LEN_W-1:0] idx;
  logic             load_simple;
  logic             load_data;
  logic             idx_inc;
  logic             out_acc;

  logic             out_status;
  logic [7:0]       out_command;
  logic [LEN_W-1:0] out_len;
  logic [LEN_W-1:0] out_index;
  logic [7:0]       out_byte;
  logic             out_last;

  assign out_acc   = res.valid && res.ready;
  assign ram_raddr = {head.bank, idx[PTR_W-1:0]};

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (not_empty) state_next = (head.kind == KIND_DATA) ? B_FETCH : B_SHOW;
      end
      B_FETCH: state_next = B_LOAD;
      B_LOAD:  state_next = B_SHOW;
      B_SHOW: begin
        if (out_acc) state_next = out_last ? B_IDLE : B_FETCH;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    load_simple = 1'b0;
    load_data   = 1'b0;
    ram_re      = 1'b0;
    pop         = 1'b0;
    idx_inc     = 1'b0;
    res.valid   = 1'b0;
    case (state)
      B_IDLE:  load_simple = not_empty && (head.kind != KIND_DATA);
      B_FETCH: ram_re = 1'b1;
      B_LOAD:  load_data = 1'b1;
      B_SHOW: begin
        res.valid = 1'b1;
        pop       = out_acc && out_last;
        idx_inc   = out_acc && !out_last;
      end
      default: res.valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (pop) begin
        idx <= '0;
      end else if (idx_inc) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_simple) begin
      out_status  <= (head.kind == KIND_ERROR) ? STATUS_ERROR : STATUS_OK;
      out_command <= head.command;
      out_len     <= head.len;
      out_index   <= '0;
      out_byte    <= '0;
      out_last    <= 1'b1;
    end else if (load_data) begin
      out_status  <= STATUS_OK;
      out_command <= head.command;
      out_len     <= head.len;
      out_index   <= idx;
      out_byte    <= ram_rdata;
      out_last    <= (idx == (head.len - 1'b1));
    end
  end

  assign res.status       = out_status;
  assign res.command      = out_command;
  assign res.payload_len  = out_len;
  assign res.byte_index   = out_index;
  assign res.payload_byte = out_byte;
  assign res.last         = out_last;

endmodule
`default_nettype wire

// ===== sim/command_packet_receiver_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// command_packet_receiver_tb
// Sends framed checksum/command/length/data packets into the receiver and
// checks every replayed result beat against a packet tracker kept in step with
// the accepted bytes. The run covers empty, clamped, long and corrupted
// packets under several register settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
module command_packet_receiver_tb import cpr_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic             status;
    logic [7:0]       command;
    logic [LEN_W-1:0] payload_len;
    logic [LEN_W-1:0] byte_index;
    logic [7:0]       payload_byte;
    logic             last;
  } beat_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cpr_rx_if  byte_ch ();
  cpr_res_if item_ch ();

  command_packet_receiver dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (byte_ch),
    .res       (item_ch)
  );

  // register shadows
  logic       sum_check_on;
  logic [7:0] long_code;

  // packet tracker
  int          hdr_seen;
  logic [15:0] sent_sum;
  logic [15:0] run_sum;
  logic [7:0]  pkt_cmd;
  logic [6:0]  pkt_len;
  logic [6:0]  pkt_left;
  logic [7:0]  pkt_data [BUFFER_BYTES];

  beat_t     due_beats [$];
  logic [7:0] tx_bytes [$];
  int        bytes_queued;
  int        errors;
  bit        calm;
  bit        hold_arm;
  bit        hold_used;
  int        hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("command_packet_receiver_tb NOT OK");
    $finish;
  end

  task automatic report(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic close_packet();
    beat_t b;
    b.command = pkt_cmd;
    b.payload_len = pkt_len[LEN_W-1:0];
    b.byte_index = '0;
    b.payload_byte = '0;
    b.last = 1'b1;
    if (pkt_len == 0) begin
      b.status = STATUS_OK;
      due_beats.push_back(b);
    end else if (sum_check_on && run_sum != sent_sum) begin
      b.status = STATUS_ERROR;
      due_beats.push_back(b);
    end else begin
      for (int k = 0; k < pkt_len; k++) begin
        b.status = STATUS_OK;
        b.byte_index = k[LEN_W-1:0];
        b.payload_byte = pkt_data[k];
        b.last = (k == pkt_len - 1);
        due_beats.push_back(b);
      end
    end
    hdr_seen = 0;
    sent_sum = '0;
    run_sum = '0;
    pkt_cmd = '0;
    pkt_len = '0;
    pkt_left = '0;
  endtask

  task automatic track_byte(input logic [7:0] b);
    int len;
    case (hdr_seen)
      0: begin
        sent_sum = {b, 8'h00};
        hdr_seen = 1;
      end
      1: begin
        sent_sum[7:0] = b;
        hdr_seen = 2;
      end
      2: begin
        pkt_cmd = b;
        run_sum = {8'h00, b};
        hdr_seen = 3;
      end
      3: begin
        len = int'(b);
        if (len > LEN_LIMIT) len = 0;
        if (pkt_cmd != long_code && len > SHORT_LIMIT) len = 0;
        pkt_len = len[6:0];
        pkt_left = len[6:0];
        run_sum = run_sum + b;
        hdr_seen = 4;
        if (len == 0) close_packet();
      end
      default: begin
        pkt_data[pkt_len - pkt_left] = b;
        run_sum = run_sum + b;
        pkt_left = pkt_left - 7'd1;
        if (pkt_left == 0) close_packet();
      end
    endcase
  endtask

  task automatic check_beat();
    beat_t want;
    if (due_beats.size() == 0) begin
      report("result beat with none due");
      return;
    end
    want = due_beats.pop_front();
    if (item_ch.status !== want.status)
      report($sformatf("status %0b, want %0b", item_ch.status, want.status));
    if (item_ch.command !== want.command)
      report($sformatf("command %0h, want %0h", item_ch.command, want.command));
    if (item_ch.payload_len !== want.payload_len)
      report($sformatf("payload_len %0d, want %0d", item_ch.payload_len, want.payload_len));
    if (item_ch.byte_index !== want.byte_index)
      report($sformatf("byte_index %0d, want %0d", item_ch.byte_index, want.byte_index));
    if (item_ch.payload_byte !== want.payload_byte)
      report($sformatf("payload_byte %0h, want %0h", item_ch.payload_byte, want.payload_byte));
    if (item_ch.last !== want.last)
      report($sformatf("last %0b, want %0b", item_ch.last, want.last));
  endtask

  // byte sender
  always @(posedge clk) begin
    if (!rst) begin
      if (byte_ch.valid && byte_ch.ready) track_byte(byte_ch.rx_byte);
      if (!byte_ch.valid || byte_ch.ready) begin
        if (tx_bytes.size() != 0 && (calm || $urandom_range(99) >= 31)) begin
          byte_ch.valid <= 1'b1;
          byte_ch.rx_byte <= tx_bytes.pop_front();
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver
  always @(posedge clk) begin
    if (rst) begin
      item_ch.ready <= 1'b0;
    end else begin
      if (item_ch.valid && item_ch.ready) check_beat();
      item_ch.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 31);
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_arm && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic set_config(input logic crc_on, input logic [7:0] code);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_CRC_CHECK_ENABLE;
    cfg_data <= {{(CFG_DATA_W-1){1'b0}}, crc_on};
    @(posedge clk);
    cfg_index <= CFG_LONG_LOAD_CODE;
    cfg_data <= code;
    @(posedge clk);
    cfg_we <= 1'b0;
    sum_check_on = crc_on;
    long_code = code;
  endtask

  task automatic queue_packet(input logic [7:0] cmd, input logic [7:0] len_byte,
                              input bit bad_sum);
    int n;
    logic [15:0] sum;
    logic [7:0] d;
    logic [7:0] body [$];
    n = int'(len_byte);
    if (n > LEN_LIMIT) n = 0;
    if (cmd != long_code && n > SHORT_LIMIT) n = 0;
    sum = {8'h00, cmd} + len_byte;
    for (int i = 0; i < n; i++) begin
      d = 8'($urandom_range(255));
      body.push_back(d);
      sum = sum + d;
    end
    if (bad_sum) sum = sum ^ 16'($urandom_range(65535, 1));
    tx_bytes.push_back(sum[15:8]);
    tx_bytes.push_back(sum[7:0]);
    tx_bytes.push_back(cmd);
    tx_bytes.push_back(len_byte);
    foreach (body[i]) tx_bytes.push_back(body[i]);
    bytes_queued += 4 + n;
  endtask

  task automatic queue_random(input int count);
    int stop;
    int pick;
    logic [7:0] cmd;
    logic [7:0] len_byte;
    stop = bytes_queued + count;
    while (bytes_queued < stop) begin
      cmd = ($urandom_range(99) < 25) ? long_code : 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 65) len_byte = 8'($urandom_range(SHORT_LIMIT, 1));
      else if (pick < 80) len_byte = 8'($urandom_range(LEN_LIMIT, SHORT_LIMIT + 1));
      else if (pick < 92) len_byte = 8'($urandom_range(255, LEN_LIMIT + 1));
      else len_byte = 8'd0;
      queue_packet(cmd, len_byte, $urandom_range(99) < 25);
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (tx_bytes.size() != 0 || byte_ch.valid || due_beats.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    byte_ch.valid = 1'b0;
    byte_ch.rx_byte = '0;
    item_ch.ready = 1'b0;
    errors = 0;
    bytes_queued = 0;
    calm = 1'b0;
    hold_arm = 1'b0;
    sum_check_on = 1'b0;
    long_code = '0;
    hdr_seen = 0;
    sent_sum = '0;
    run_sum = '0;
    pkt_cmd = '0;
    pkt_len = '0;
    pkt_left = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    set_config(1'b1, 8'hA5);
    queue_packet(8'h00, 8'd0, 1'b0);
    queue_packet(8'h12, 8'd1, 1'b0);
    queue_packet(8'hFF, 8'd10, 1'b0);
    queue_packet(8'h33, 8'd11, 1'b0);
    queue_packet(8'h44, 8'd3, 1'b1);
    queue_packet(8'hA5, 8'd61, 1'b0);
    queue_packet(8'hA5, 8'd12, 1'b0);
    queue_packet(8'h01, 8'd255, 1'b0);
    wait_idle();

    // checks off, code 0 treated as long load; hold results to back up input
    set_config(1'b0, 8'h00);
    hold_arm = 1'b1;
    queue_random(80);
    wait_idle();

    calm = 1'b1;
    set_config(1'b1, 8'hFF);
    queue_packet(8'hFF, 8'd60, 1'b0);
    queue_packet(8'hFF, 8'd60, 1'b1);
    queue_random(40);
    wait_idle();

    calm = 1'b0;
    set_config(1'b1, 8'($urandom_range(255)));
    queue_random(90);
    wait_idle();

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("command_packet_receiver_tb OK");
    end else begin
      $display("command_packet_receiver_tb NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/cpr_pkg.sv
rtl/core/cpr_if.sv
rtl/core/cpr_ram.sv
rtl/core/cpr_front.sv
rtl/core/cpr_desc_fifo.sv
rtl/core/cpr_back.sv
rtl/core/command_packet_receiver.sv
sim/command_packet_receiver_tb.sv
